FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with delete by value.
// ----------------------------------------------------------------------------
package deq_pkg;

    // default sizing
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_WORD_BITS = 32;

    // fixed field widths on the request and result channels
    localparam int KIND_BITS   = 3;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    // request kinds
    localparam logic [KIND_BITS-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_POP_BACK   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_DELETE     = 3'd4;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    // read address select
    typedef enum logic [1:0] {
        RD_BACK  = 2'd0,
        RD_FRONT = 2'd1,
        RD_NEXT  = 2'd2,
        RD_NEXT2 = 2'd3
    } t_rd_sel;

    // write address select
    typedef enum logic [1:0] {
        WR_BACK  = 2'd0,
        WR_FRONT = 2'd1,
        WR_SHIFT = 2'd2
    } t_wr_sel;

    // controller to datapath commands
    typedef struct packed {
        logic    req_load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    occ_inc;
        logic    occ_dec;
        logic    front_inc;
        logic    front_dec;
        logic    res_load;
        logic    res_pop;
        t_status res_status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 full;
        logic                 empty;
        logic                 match;
        logic                 has_next;
        logic                 has_next2;
        logic                 res_free;
    } t_sts;

endpackage

FILE: rtl/core/deq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: kind and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [KIND_BITS-1:0]         kind;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

FILE: rtl/core/deq_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_res_if
// Result channel: popped word, status and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface deq_res_if;
    import deq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] popped_value;
    logic [STATUS_BITS-1:0]       status;
    logic [COUNT_BITS-1:0]        entry_count;

    modport source (output valid, output popped_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entry_count, output ready);

endinterface

FILE: rtl/core/deque_with_delete_by_value_unit.sv
`timescale 1ns / 1ps
// push: the request is latched, then the result is loaded in the execute state
// pop: the store is read in the execute state, the result loaded in the pop-wait state
// delete: one entry compared or moved per cycle through the single read port of the store
// one request in flight; the next is taken when the result register is empty
//   or drains in that cycle, and only once the last request is back in idle
// reset (synchronous, active low) empties the queue; the store is not cleared
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_unit
// Bounded double-ended queue of signed words with delete by value.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_unit #(
    parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_req_if.sink   i_req,
    deq_res_if.source o_res
);
    import deq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // store and pointers
    deq_dpath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_req_kind         (i_req.kind),
        .i_req_value        (i_req.value),
        .i_res_ready        (o_res.ready),
        .o_res_valid        (o_res.valid),
        .o_res_popped_value (o_res.popped_value),
        .o_res_status       (o_res.status),
        .o_res_entry_count  (o_res.entry_count)
    );

endmodule

FILE: rtl/core/deq_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dpath
// Ring store, front/occupancy pointers, scan index and result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  deq_pkg::t_cmd                         i_cmd,
    output deq_pkg::t_sts                         o_sts,
    input  logic [deq_pkg::KIND_BITS-1:0]         i_req_kind,
    input  logic signed [deq_pkg::VALUE_BITS-1:0] i_req_value,
    input  logic                                  i_res_ready,
    output logic                                  o_res_valid,
    output logic signed [deq_pkg::VALUE_BITS-1:0] o_res_popped_value,
    output logic [deq_pkg::STATUS_BITS-1:0]       o_res_status,
    output logic [deq_pkg::COUNT_BITS-1:0]        o_res_entry_count
);
    import deq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // ring store
    logic signed [WORD_BITS-1:0] r_mem [CAPACITY];
    logic signed [WORD_BITS-1:0] r_rd_data;

    // request and pointer state
    logic [KIND_BITS-1:0]        r_kind;
    logic signed [WORD_BITS-1:0] r_word;
    logic [AW-1:0]               r_front, n_front;
    logic [CW-1:0]               r_occ, n_occ;
    logic [AW-1:0]               r_idx, n_idx;

    // result register
    logic                        r_out_valid;
    logic signed [VALUE_BITS-1:0] r_popped;
    logic [STATUS_BITS-1:0]      r_status;
    logic [COUNT_BITS-1:0]       r_count;

    logic [AW-1:0]               front_prev;
    logic [AW-1:0]               front_next;
    logic [CW:0]                 rd_off;
    logic [CW:0]                 wr_off;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic signed [WORD_BITS-1:0] wr_data;
    logic [CW:0]                 idx_p1;
    logic [CW:0]                 idx_p2;

    // ring position of an offset from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW:0] off);
        logic [CW+1:0] sum;
        sum = (CW+2)'(front) + (CW+2)'(off);
        if (sum >= (CW+2)'(CAPACITY)) begin
            sum = sum - (CW+2)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    // front neighbors with wrap
    assign front_prev = (r_front == '0) ? AW'(CAPACITY - 1) : r_front - 1'b1;
    assign front_next = (r_front == AW'(CAPACITY - 1)) ? '0 : r_front + 1'b1;

    assign idx_p1 = (CW+1)'(r_idx) + (CW+1)'(1);
    assign idx_p2 = (CW+1)'(r_idx) + (CW+1)'(2);

    // read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_BACK:  rd_off = (CW+1)'(r_occ) - (CW+1)'(1);
            RD_FRONT: rd_off = '0;
            RD_NEXT:  rd_off = idx_p1;
            RD_NEXT2: rd_off = idx_p2;
            default:  rd_off = '0;
        endcase
    end
    assign rd_addr = slot_of(r_front, rd_off);

    // write address and data
    always_comb begin
        wr_off  = (CW+1)'(r_occ);
        wr_data = r_word;
        case (i_cmd.wr_sel)
            WR_BACK: begin
                wr_off = (CW+1)'(r_occ);
            end
            WR_SHIFT: begin
                wr_off  = (CW+1)'(r_idx);
                wr_data = r_rd_data;
            end
            default: begin
                wr_off = '0;
            end
        endcase
    end
    assign wr_addr = (i_cmd.wr_sel == WR_FRONT) ? front_prev : slot_of(r_front, wr_off);

    // store access, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // next pointer values
    always_comb begin
        n_occ = r_occ;
        if (i_cmd.occ_inc) begin
            n_occ = r_occ + 1'b1;
        end else if (i_cmd.occ_dec) begin
            n_occ = r_occ - 1'b1;
        end
        n_front = r_front;
        if (i_cmd.front_inc) begin
            n_front = front_next;
        end else if (i_cmd.front_dec) begin
            n_front = front_prev;
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_occ   <= n_occ;
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch, scan index and result payload
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.req_load) begin
            r_kind <= i_req_kind;
            r_word <= WORD_BITS'(i_req_value);
        end
        if (i_cmd.res_load) begin
            r_popped <= i_cmd.res_pop ? VALUE_BITS'(r_rd_data) : '0;
            r_status <= i_cmd.res_status;
            r_count  <= COUNT_BITS'(n_occ);
        end
    end

    // status to the controller
    assign o_sts.kind      = r_kind;
    assign o_sts.full      = (r_occ == CW'(CAPACITY));
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.match     = (r_rd_data == r_word);
    assign o_sts.has_next  = (idx_p1 < (CW+1)'(r_occ));
    assign o_sts.has_next2 = (idx_p2 < (CW+1)'(r_occ));
    assign o_sts.res_free  = !r_out_valid || i_res_ready;

    assign o_res_valid        = r_out_valid;
    assign o_res_popped_value = r_popped;
    assign o_res_status       = r_status;
    assign o_res_entry_count  = r_count;

endmodule

FILE: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for push, pop and delete-with-compaction requests.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_POPW = 5'b00100,
        S_SCAN = 5'b01000,
        S_MOVE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   req_acc;

    // take a request only when idle and the result slot frees up
    assign o_req_ready = (r_state == S_IDLE) && i_sts.res_free;
    assign req_acc     = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.req_load = req_acc;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_sts.kind)
                    KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.occ_inc    = 1'b1;
                            o_cmd.res_status = ST_OK;
                            if (i_sts.kind == KIND_PUSH_FRONT) begin
                                o_cmd.wr_sel    = WR_FRONT;
                                o_cmd.front_dec = 1'b1;
                            end else begin
                                o_cmd.wr_sel = WR_BACK;
                            end
                        end
                    end
                    KIND_POP_BACK, KIND_POP_FRONT: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = (i_sts.kind == KIND_POP_FRONT) ? RD_FRONT
                                                                           : RD_BACK;
                            n_state      = S_POPW;
                        end
                    end
                    KIND_DELETE: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NOMATCH;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_FRONT;
                            n_state       = S_SCAN;
                        end
                    end
                    default: begin
                        // unused kind codes leave the queue alone
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_POPW: begin
                // read data is back, retire the pop
                o_cmd.res_load   = 1'b1;
                o_cmd.res_pop    = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.occ_dec    = 1'b1;
                o_cmd.front_inc  = (i_sts.kind == KIND_POP_FRONT);
                n_state          = S_IDLE;
            end
            S_SCAN: begin
                // compare one entry a cycle from the front
                if (i_sts.match) begin
                    if (i_sts.has_next) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_NEXT;
                        n_state      = S_MOVE;
                    end else begin
                        o_cmd.occ_dec    = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.has_next) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_NEXT;
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOMATCH;
                    n_state          = S_IDLE;
                end
            end
            S_MOVE: begin
                // shift the following entry down by one to close the gap
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_SHIFT;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.has_next2) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT2;
                end else begin
                    o_cmd.occ_dec    = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded double-ended queue with delete by value.
// Requests go in over the request channel. A shadow queue predicts the popped
// word, the status and the entry count of every request, and each result is
// checked against the oldest prediction. Directed requests cover the empty and
// full corners and delete hits and misses. Random traffic with shifting fill
// pressure follows, first under sender and receiver stalls and then without.
// ----------------------------------------------------------------------------
module tb_top;
    import deq_pkg::*;

    localparam int DEPTH          = DEF_CAPACITY;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    // highest of the unused request kinds
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 3'd7;

    // expected fields of one result
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] popped_value;
        t_status                      status;
        logic [COUNT_BITS-1:0]        entry_count;
    } t_deq_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_req_if req_bus ();
    deq_res_if res_bus ();

    // shadow copy of the queue contents, front at index 0
    logic signed [VALUE_BITS-1:0] deque_shadow[$];
    // predictions waiting for their result
    t_deq_outcome pending_outcomes[$];

    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    deque_with_delete_by_value_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // known values on every input from time zero
    initial begin
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.kind  = KIND_PUSH_BACK;
        req_bus.value = '0;
        res_bus.ready = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict the result of one request and update the shadow queue
    function automatic t_deq_outcome predict_deque_op(
        input logic [KIND_BITS-1:0]         kind,
        input logic signed [VALUE_BITS-1:0] value
    );
        t_deq_outcome outc;
        int hit;
        outc.popped_value = '0;
        outc.status       = ST_OK;
        hit               = -1;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (deque_shadow.size() >= DEPTH) begin
                    outc.status = ST_FULL;
                end else if (kind == KIND_PUSH_BACK) begin
                    deque_shadow.push_back(value);
                end else begin
                    deque_shadow.push_front(value);
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
                if (deque_shadow.size() == 0) begin
                    outc.status = ST_EMPTY;
                end else if (kind == KIND_POP_BACK) begin
                    outc.popped_value = deque_shadow.pop_back();
                end else begin
                    outc.popped_value = deque_shadow.pop_front();
                end
            end
            KIND_DELETE: begin
                // first match seen from the front
                foreach (deque_shadow[i]) begin
                    if (hit < 0 && deque_shadow[i] == value) hit = i;
                end
                if (hit < 0) begin
                    outc.status = ST_NOMATCH;
                end else begin
                    deque_shadow.delete(hit);
                end
            end
            default: ;
        endcase
        outc.entry_count = COUNT_BITS'(deque_shadow.size());
        return outc;
    endfunction

    // send one request, returns at the falling edge after it was taken
    task automatic send_request(
        input logic [KIND_BITS-1:0]         kind,
        input logic signed [VALUE_BITS-1:0] value
    );
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind  <= kind;
        req_bus.value <= value;
        do @(posedge i_clk); while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
        pending_outcomes.push_back(predict_deque_op(req_bus.kind, req_bus.value));
        @(negedge i_clk);
    endtask

    // stop sending until every pending result has come back
    task automatic hold_until_drained();
        req_bus.valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        @(negedge i_clk);
    endtask

    // word mix: full random, small values that repeat, and extremes
    function automatic logic signed [VALUE_BITS-1:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $signed($urandom_range(7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // pops on empty, delete on empty, unused kind
    task automatic test_empty_queue();
        send_request(KIND_POP_BACK, 32'sd0);
        send_request(KIND_POP_FRONT, -32'sd1);
        send_request(KIND_DELETE, 32'sd0);
        send_request(KIND_UNUSED, 32'sh7FFF_FFFF);
    endtask

    // fill from both ends, then push into the full queue at both ends
    task automatic test_fill_to_capacity();
        logic signed [VALUE_BITS-1:0] fill_words [16] = '{
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,         -32'sd1,
            32'sd5,         32'sh5555_5555, 32'shAAAA_AAAA, 32'sd5,
            -32'sd5,        32'sd1,         32'sh1234_5678, 32'shFEDC_BA98,
            32'sd5,         32'sd2,         32'sd3,         32'sh0001_0000
        };
        for (int i = 0; i < 16; i++) begin
            send_request((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, fill_words[i]);
        end
        send_request(KIND_PUSH_BACK, 32'sd77);
        send_request(KIND_PUSH_FRONT, -32'sd77);
    endtask

    // delete a repeated value, the back entry, the front entry and a miss
    task automatic test_delete_cases();
        send_request(KIND_DELETE, 32'sd5);
        send_request(KIND_DELETE, 32'sd3);
        send_request(KIND_DELETE, 32'sh0001_0000);
        send_request(KIND_DELETE, 32'sh0BAD_F00D);
    endtask

    // random traffic; fill pressure changes every few dozen requests
    task automatic test_random_traffic(input int n_items, input bit pause_midway);
        int fill_bias;
        int roll;
        logic [KIND_BITS-1:0] kind;
        logic signed [VALUE_BITS-1:0] value;
        fill_bias = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) fill_bias = $urandom_range(20, 85);
            if (pause_midway && i == n_items / 2) hold_until_drained();
            roll = $urandom_range(99);
            if (roll < 3) begin
                kind  = KIND_BITS'($urandom_range(KIND_DELETE + 1, KIND_UNUSED));
                value = $urandom;
            end else if (roll < 15) begin
                kind = KIND_DELETE;
                if (deque_shadow.size() != 0 && $urandom_range(3) != 0) begin
                    value = deque_shadow[$urandom_range(deque_shadow.size() - 1)];
                end else begin
                    value = pick_word();
                end
            end else if ($urandom_range(99) < fill_bias) begin
                kind  = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                value = pick_word();
            end else begin
                kind  = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
                value = $urandom;
            end
            send_request(kind, value);
        end
    endtask

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_deq_outcome want;
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result popped %0d status %0d count %0d", $time,
                         res_bus.popped_value, res_bus.status, res_bus.entry_count);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (res_bus.popped_value !== want.popped_value) begin
                    $display("%0t: popped_value expected %0d actual %0d", $time,
                             want.popped_value, res_bus.popped_value);
                    fail_count++;
                end
                if (res_bus.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, res_bus.status);
                    fail_count++;
                end
                if (res_bus.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.entry_count, res_bus.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no result taken
    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 30;
        recv_idle_pct = 58;
        test_empty_queue();
        test_fill_to_capacity();
        test_delete_cases();
        test_random_traffic(140, 1'b1);

        // roles swapped
        send_idle_pct = 58;
        recv_idle_pct = 30;
        test_random_traffic(130, 1'b0);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(130, 1'b0);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
